FILE: src/atn_pkg.sv
// shared constants, types and the arctangent table of the tilt block
package atn_pkg;

   // defaults of the top-level parameters
   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;

   // field widths
   localparam int AXIS_W  = 16;
   localparam int CPG_W   = 15;
   localparam int TILT_W  = 15;

   // datapath widths
   localparam int ABS_W   = AXIS_W + 1;        // magnitude of a 16-bit sample
   localparam int SQ_W    = 2 * AXIS_W - 1;    // square of one axis
   localparam int LSQ_W   = 2 * CPG_W;         // counts_per_g squared
   localparam int CMP_W   = 36;                // width of the norm compare
   localparam int GAIN_W  = 31;
   localparam int PROD_W  = ABS_W + GAIN_W;
   localparam int ZS_W    = 33;                // |z| scaled by 2^16 and the cordic gain
   localparam int CORDIC_W = 36;               // x and y of both vectoring passes
   localparam int ACC_W   = 32;                // angle in degrees * 2^24
   localparam int ACC_FRAC = 24;
   localparam int SAMPLE_SHIFT = 16;
   localparam int GAIN_SHIFT = 30 - SAMPLE_SHIFT;

   // cordic gain in Q30
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;

   // ninety degrees in the accumulator format
   localparam logic signed [ACC_W-1:0] ANGLE_MAX = 32'sd1509949440;

   localparam logic [ACC_W-1:0] TILT_MAX = 32'd32767;

   // side data layout: [0] norm flag, [1] all-zero sample, above that scaled |z|
   localparam int SIDE_W    = 2;
   localparam int P1_SIDE_W = ZS_W + SIDE_W;
   localparam int SIDE_NORM = 0;
   localparam int SIDE_ZERO = 1;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ACC_W-1:0]    z;
   } cordic_type;

   // atan(2^-i) in degrees * 2^24, rounded to nearest
   function automatic logic signed [ACC_W-1:0] atan_deg(input int idx);
      logic signed [ACC_W-1:0] r;
      case (idx)
         0:       r = 32'sd754974720;
         1:       r = 32'sd445687602;
         2:       r = 32'sd235489089;
         3:       r = 32'sd119537938;
         4:       r = 32'sd60000934;
         5:       r = 32'sd30029717;
         6:       r = 32'sd15018523;
         7:       r = 32'sd7509720;
         8:       r = 32'sd3754917;
         9:       r = 32'sd1877466;
         10:      r = 32'sd938734;
         11:      r = 32'sd469367;
         12:      r = 32'sd234684;
         13:      r = 32'sd117342;
         14:      r = 32'sd58671;
         15:      r = 32'sd29335;
         16:      r = 32'sd14668;
         17:      r = 32'sd7334;
         18:      r = 32'sd3667;
         19:      r = 32'sd1833;
         20:      r = 32'sd917;
         21:      r = 32'sd458;
         22:      r = 32'sd229;
         23:      r = 32'sd115;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/atn_front.sv
// input stages: magnitudes, gain scaling of z and the norm plausibility check
module atn_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [atn_pkg::AXIS_W-1:0]     accel_x,
   input  logic signed [atn_pkg::AXIS_W-1:0]     accel_y,
   input  logic signed [atn_pkg::AXIS_W-1:0]     accel_z,
   input  logic [atn_pkg::CPG_W-1:0]             counts_per_g,
   output logic                                  out_valid,
   output atn_pkg::cordic_type                   out_vec,
   output logic [atn_pkg::P1_SIDE_W-1:0]         out_side
);

   localparam int ABS_W  = atn_pkg::ABS_W;
   localparam int SQ_W   = atn_pkg::SQ_W;
   localparam int LSQ_W  = atn_pkg::LSQ_W;
   localparam int CMP_W  = atn_pkg::CMP_W;
   localparam int PROD_W = atn_pkg::PROD_W;
   localparam int ZS_W   = atn_pkg::ZS_W;
   localparam int W      = atn_pkg::CORDIC_W;

   logic [ABS_W-1:0]  ext_x, ext_y, ext_z;
   logic [ABS_W-1:0]  abs_x_in, abs_y_in, abs_z_in;
   logic [2*atn_pkg::AXIS_W-1:0] sq_x, sq_y, sq_z;

   logic              v1_ff;
   logic [ABS_W-1:0]  abs_x_ff, abs_y_ff;
   logic [PROD_W-1:0] zprod_ff, zprod_in;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic [LSQ_W-1:0]  lsq_ff, lsq_in;
   logic              zero_ff, zero_in;

   logic [CMP_W-1:0]  sum_s, s16, l9, l25;
   logic              norm_in;
   atn_pkg::cordic_type vec_ff, vec_in;
   logic [ZS_W-1:0]   zs_ff, zs_in;
   logic              v2_ff, norm_ff, zero2_ff;

   // magnitudes of the sign-extended samples
   assign ext_x = {accel_x[atn_pkg::AXIS_W-1], accel_x};
   assign ext_y = {accel_y[atn_pkg::AXIS_W-1], accel_y};
   assign ext_z = {accel_z[atn_pkg::AXIS_W-1], accel_z};
   assign abs_x_in = ext_x[ABS_W-1] ? (~ext_x + ABS_W'(1)) : ext_x;
   assign abs_y_in = ext_y[ABS_W-1] ? (~ext_y + ABS_W'(1)) : ext_y;
   assign abs_z_in = ext_z[ABS_W-1] ? (~ext_z + ABS_W'(1)) : ext_z;

   // squares and products, one multiplier per path
   assign sq_x     = (2*atn_pkg::AXIS_W)'(accel_x * accel_x);
   assign sq_y     = (2*atn_pkg::AXIS_W)'(accel_y * accel_y);
   assign sq_z     = (2*atn_pkg::AXIS_W)'(accel_z * accel_z);
   assign lsq_in   = LSQ_W'(counts_per_g) * LSQ_W'(counts_per_g);
   assign zprod_in = PROD_W'(abs_z_in) * PROD_W'(atn_pkg::GAIN_Q30);
   assign zero_in  = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);

   // first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
         zprod_ff <= zprod_in;
         sqx_ff   <= sq_x[SQ_W-1:0];
         sqy_ff   <= sq_y[SQ_W-1:0];
         sqz_ff   <= sq_z[SQ_W-1:0];
         lsq_ff   <= lsq_in;
         zero_ff  <= zero_in;
      end
   end

   // norm window: 9*L*L <= 16*S <= 25*L*L, never set for L of zero
   assign sum_s = CMP_W'(sqx_ff) + CMP_W'(sqy_ff) + CMP_W'(sqz_ff);
   assign s16   = sum_s << 4;
   assign l9    = (CMP_W'(lsq_ff) << 3) + CMP_W'(lsq_ff);
   assign l25   = (CMP_W'(lsq_ff) << 4) + (CMP_W'(lsq_ff) << 3) + CMP_W'(lsq_ff);
   assign norm_in = (lsq_ff != '0) && (l9 <= s16) && (s16 <= l25);

   // starting vector of the first pass, samples carry 16 fraction bits
   assign zs_in    = zprod_ff[atn_pkg::GAIN_SHIFT +: ZS_W];
   assign vec_in.x = W'(abs_x_ff) << atn_pkg::SAMPLE_SHIFT;
   assign vec_in.y = W'(abs_y_ff) << atn_pkg::SAMPLE_SHIFT;
   assign vec_in.z = '0;

   // second stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         vec_ff   <= vec_in;
         zs_ff    <= zs_in;
         norm_ff  <= norm_in;
         zero2_ff <= zero_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_vec   = vec_ff;
   assign out_side  = {zs_ff, zero2_ff, norm_ff};

endmodule

FILE: src/atn_cell.sv
// one cordic vectoring iteration with its pipeline register
module atn_cell #(
   parameter int STEP   = 0,
   parameter int SIDE_W = atn_pkg::SIDE_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  atn_pkg::cordic_type in_vec,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output atn_pkg::cordic_type out_vec,
   output logic [SIDE_W-1:0]   out_side
);

   localparam logic signed [atn_pkg::ACC_W-1:0] ANG = atn_pkg::atan_deg(STEP);

   logic signed [atn_pkg::CORDIC_W-1:0] dx, dy;
   atn_pkg::cordic_type vec_ff, vec_in;
   logic [SIDE_W-1:0]   side_ff;
   logic                valid_ff;

   // rotate toward the x axis, direction from the sign of y
   assign dx = in_vec.y >>> STEP;
   assign dy = in_vec.x >>> STEP;

   always_comb begin
      if (!in_vec.y[atn_pkg::CORDIC_W-1]) begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ANG;
      end else begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         vec_ff  <= vec_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

FILE: src/atn_back.sv
// angle clamp and rounding into the output register
module atn_back #(
   parameter int ANGLE_FRAC_BITS = atn_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [atn_pkg::ACC_W-1:0]   in_z,
   input  logic [atn_pkg::SIDE_W-1:0]         in_side,
   output logic                               out_valid,
   output logic [atn_pkg::TILT_W-1:0]         out_tilt,
   output logic                               out_norm
);

   localparam int ACC_W = atn_pkg::ACC_W;
   localparam int SHIFT = atn_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);

   logic signed [ACC_W-1:0] zc;
   logic [ACC_W-1:0]        rnd;
   logic [atn_pkg::TILT_W-1:0] tilt_in, tilt_ff;
   logic                    valid_ff, norm_ff;

   // clamp to zero..ninety degrees, round half up, saturate to the field; an all-zero sample gives zero
   always_comb begin
      if (in_z[ACC_W-1]) begin
         zc = '0;
      end else if (in_z > atn_pkg::ANGLE_MAX) begin
         zc = atn_pkg::ANGLE_MAX;
      end else begin
         zc = in_z;
      end
      rnd = (ACC_W'(zc) + HALF) >> SHIFT;
      if (in_side[atn_pkg::SIDE_ZERO]) begin
         tilt_in = '0;
      end else if (rnd > atn_pkg::TILT_MAX) begin
         tilt_in = atn_pkg::TILT_MAX[atn_pkg::TILT_W-1:0];
      end else begin
         tilt_in = rnd[atn_pkg::TILT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         tilt_ff <= tilt_in;
         norm_ff <= in_side[atn_pkg::SIDE_NORM];
      end
   end

   assign out_valid = valid_ff;
   assign out_tilt  = tilt_ff;
   assign out_norm  = norm_ff;

endmodule

FILE: src/accel_tilt_and_norm_check.sv
// top level: accelerometer tilt angle and norm plausibility pipeline
//
// Usage: one three-axis sample enters on the req_ channel (valid/ready) and
// exactly one result leaves on the rsp_ channel: the tilt from vertical in
// units of 2^-ANGLE_FRAC_BITS degree and a flag set when the vector norm lies
// within 0.75 g to 1.25 g of counts_per_g.
// counts_per_g is written through csr_wr_en/csr_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Stages from transfer to rsp_valid: two input stages, one cell per iteration
// in each of the two vectoring passes, and the output register.
// Throughput: one sample per cycle; every stage, including each cordic cell,
// takes a new sample in every cycle the pipeline advances.
// The pipeline advances whenever the output register is empty or its result is
// taken in the same cycle; while the receiver holds rsp_ready low with a result
// waiting, the whole chain holds and req_ready is low.
// Reset clears all valid bits and sets counts_per_g to 16384.
module accel_tilt_and_norm_check #(
   parameter int CORDIC_STEPS    = atn_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = atn_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [atn_pkg::AXIS_W-1:0] req_accel_x,
   input  logic signed [atn_pkg::AXIS_W-1:0] req_accel_y,
   input  logic signed [atn_pkg::AXIS_W-1:0] req_accel_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [atn_pkg::TILT_W-1:0]        rsp_tilt_angle,
   output logic                              rsp_norm_ok,
   input  logic                              csr_wr_en,
   input  logic [atn_pkg::CPG_W-1:0]         csr_wr_data
);

   localparam int W    = atn_pkg::CORDIC_W;
   localparam int ZS_W = atn_pkg::ZS_W;
   localparam int P1W  = atn_pkg::P1_SIDE_W;
   localparam int P2W  = atn_pkg::SIDE_W;

   logic [atn_pkg::CPG_W-1:0] cpg_ff;
   logic                      adv;

   logic                p1_valid [0:CORDIC_STEPS];
   atn_pkg::cordic_type p1_vec   [0:CORDIC_STEPS];
   logic [P1W-1:0]      p1_side  [0:CORDIC_STEPS];
   logic                p2_valid [0:CORDIC_STEPS];
   atn_pkg::cordic_type p2_vec   [0:CORDIC_STEPS];
   logic [P2W-1:0]      p2_side  [0:CORDIC_STEPS];

   // counts per g register
   always_ff @(posedge clock) begin
      if (reset) begin
         cpg_ff <= atn_pkg::CPG_W'(16384);
      end else if (csr_wr_en) begin
         cpg_ff <= csr_wr_data;
      end
   end

   // chain advances unless a result is stuck at the output
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   atn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (req_valid),
      .accel_x      (req_accel_x),
      .accel_y      (req_accel_y),
      .accel_z      (req_accel_z),
      .counts_per_g (cpg_ff),
      .out_valid    (p1_valid[0]),
      .out_vec      (p1_vec[0]),
      .out_side     (p1_side[0])
   );

   // first pass: rotate (|x|, |y|) onto the x axis, giving K*hypot
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pass1
      atn_cell #(.STEP(k), .SIDE_W(P1W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (p1_valid[k]),
         .in_vec    (p1_vec[k]),
         .in_side   (p1_side[k]),
         .out_valid (p1_valid[k+1]),
         .out_vec   (p1_vec[k+1]),
         .out_side  (p1_side[k+1])
      );
   end

   // second pass starts from (K*|z|, K*hypot) with a cleared angle
   assign p2_valid[0] = p1_valid[CORDIC_STEPS];
   assign p2_vec[0].x = W'(p1_side[CORDIC_STEPS][P2W +: ZS_W]);
   assign p2_vec[0].y = p1_vec[CORDIC_STEPS].x;
   assign p2_vec[0].z = '0;
   assign p2_side[0]  = p1_side[CORDIC_STEPS][P2W-1:0];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pass2
      atn_cell #(.STEP(k), .SIDE_W(P2W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (p2_valid[k]),
         .in_vec    (p2_vec[k]),
         .in_side   (p2_side[k]),
         .out_valid (p2_valid[k+1]),
         .out_vec   (p2_vec[k+1]),
         .out_side  (p2_side[k+1])
      );
   end

   atn_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p2_valid[CORDIC_STEPS]),
      .in_z      (p2_vec[CORDIC_STEPS].z),
      .in_side   (p2_side[CORDIC_STEPS]),
      .out_valid (rsp_valid),
      .out_tilt  (rsp_tilt_angle),
      .out_norm  (rsp_norm_ok)
   );

endmodule

FILE: verif/tb_accel_tilt_and_norm_check.sv
// self-checking testbench of the accelerometer tilt and norm check pipeline
module tb_accel_tilt_and_norm_check;

   localparam int TILT_STEPS   = atn_pkg::CORDIC_STEPS_DEF;
   localparam int TILT_FRAC    = atn_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int ATAN_LEN     = 24;
   localparam int Q24_FRAC     = 24;
   localparam int CPG_RESET    = 16384;
   localparam int SETTLE_CYCLES = 2 * TILT_STEPS + 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic signed [atn_pkg::AXIS_W-1:0] axis_type;
   typedef logic [atn_pkg::CPG_W-1:0] cpg_type;

   typedef struct {
      logic [atn_pkg::TILT_W-1:0] tilt_angle;
      logic                       norm_ok;
   } tilt_result_type;

   // dut ports
   logic  clock = 1'b0;
   logic  reset = 1'b1;
   logic  req_valid = 1'b0;
   logic  req_ready;
   axis_type req_accel_x = '0;
   axis_type req_accel_y = '0;
   axis_type req_accel_z = '0;
   logic  rsp_valid;
   logic  rsp_ready = 1'b0;
   logic [atn_pkg::TILT_W-1:0] rsp_tilt_angle;
   logic  rsp_norm_ok;
   logic  csr_wr_en = 1'b0;
   cpg_type csr_wr_data = '0;

   // arctangent of 2^-i in degrees scaled by 2^24
   longint atan_q24 [ATAN_LEN] = '{
      754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   tilt_result_type awaited_results [$];
   tilt_result_type head;
   cpg_type cpg_shadow = cpg_type'(CPG_RESET);
   int   fail_count = 0;
   int   burst_left = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   int   stall_mode = 0;

   accel_tilt_and_norm_check dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tilt_angle (rsp_tilt_angle),
      .rsp_norm_ok    (rsp_norm_ok),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint axis_mag(input axis_type v);
      longint w;
      w = longint'(v);
      return (w < 0) ? -w : w;
   endfunction

   function automatic longint isqrt(input longint v);
      longint r;
      longint b;
      r = 0;
      for (int i = 20; i >= 0; i--) begin
         b = r | (longint'(1) << i);
         if (b * b <= v) begin
            r = b;
         end
      end
      return r;
   endfunction

   function automatic axis_type sat_axis(input longint v);
      if (v > 32767) begin
         return axis_type'(32767);
      end
      if (v < -32768) begin
         return axis_type'(-32768);
      end
      return axis_type'(v);
   endfunction

   // tilt from vertical: magnitude pass on (x, y), then angle pass against gain-scaled |z|
   function automatic logic [atn_pkg::TILT_W-1:0] calc_tilt_angle(input axis_type ax,
                                                                  input axis_type ay,
                                                                  input axis_type az);
      longint x, y, ang, dx, dy;
      longint unsigned zs, r;
      if (ax == 0 && ay == 0 && az == 0) begin
         return '0;
      end
      x = axis_mag(ax) * 65536;
      y = axis_mag(ay) * 65536;
      for (int i = 0; i < TILT_STEPS && i < ATAN_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
         end else begin
            x = x - dx;
            y = y + dy;
         end
      end
      y = x;
      zs = (longint'(axis_mag(az)) * 64'd65536 * 64'd1768195363) >> 30;
      x = longint'(zs);
      ang = 0;
      for (int i = 0; i < TILT_STEPS && i < ATAN_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            ang = ang + atan_q24[i];
         end else begin
            x = x - dx;
            y = y + dy;
            ang = ang - atan_q24[i];
         end
      end
      // clamp to 0..90 degrees, then round half up to the output scale
      if (ang < 0) begin
         ang = 0;
      end
      if (ang > (longint'(90) << Q24_FRAC)) begin
         ang = longint'(90) << Q24_FRAC;
      end
      r = (longint'(ang) + (longint'(1) << (Q24_FRAC - 1 - TILT_FRAC))) >>
          (Q24_FRAC - TILT_FRAC);
      if (r > 32767) begin
         r = 32767;
      end
      return r[atn_pkg::TILT_W-1:0];
   endfunction

   // norm within 0.75 g .. 1.25 g, exact integer compare
   function automatic logic calc_norm_ok(input axis_type ax, input axis_type ay,
                                         input axis_type az, input cpg_type cpg);
      longint s, l2;
      if (cpg == 0) begin
         return 1'b0;
      end
      s = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay) +
          longint'(az) * longint'(az);
      l2 = longint'(cpg) * longint'(cpg);
      return (9 * l2 <= 16 * s) && (16 * s <= 25 * l2);
   endfunction

   // one sample transfer, sender idles in bursts with random gaps
   task automatic send_sample(input axis_type ax, input axis_type ay, input axis_type az);
      int gap;
      tilt_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res.tilt_angle = calc_tilt_angle(ax, ay, az);
      res.norm_ok    = calc_norm_ok(ax, ay, az, cpg_shadow);
      awaited_results.push_back(res);
   endtask

   // stop sending and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_counts_per_g(input cpg_type value);
      while (awaited_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cpg_shadow = value;
   endtask

   // half of them vectors near one g in random directions, plus noise and sparse axes
   task automatic send_random_sample();
      longint c [3];
      axis_type s [3];
      longint rem, r;
      int kind, base, m, rot;
      kind = $urandom_range(0, 99);
      base = (cpg_shadow == 0) ? CPG_RESET : int'(cpg_shadow);
      if (kind < 50) begin
         m = base * int'($urandom_range(60, 140)) / 100;
         c[0] = longint'(int'($urandom_range(0, 2 * m)) - m);
         rem = longint'(m) * m - c[0] * c[0];
         r = isqrt(rem);
         c[1] = longint'($urandom_range(0, 2 * r)) - r;
         rem = rem - c[1] * c[1];
         c[2] = isqrt(rem);
         if ($urandom_range(0, 1) == 1) begin
            c[2] = -c[2];
         end
         rot = $urandom_range(0, 2);
         for (int k = 0; k < 3; k++) begin
            s[(rot + k) % 3] = sat_axis(c[k]);
         end
      end else if (kind < 70) begin
         for (int k = 0; k < 3; k++) begin
            s[k] = axis_type'($urandom());
         end
      end else if (kind < 85) begin
         for (int k = 0; k < 3; k++) begin
            s[k] = axis_type'(int'($urandom_range(0, 6)) - 3);
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            s[k] = ($urandom_range(0, 1) == 1) ? axis_type'($urandom()) : axis_type'(0);
         end
      end
      send_sample(s[0], s[1], s[2]);
   endtask

   task automatic send_random_run(input int count);
      for (int n = 0; n < count; n++) begin
         send_random_sample();
      end
   endtask

   // field extremes, pure axes, zero sample and norm edges at the reset scale
   task automatic test_directed_extremes();
      send_sample(0, 0, 0);
      send_sample(32767, 0, 0);
      send_sample(-32768, 0, 0);
      send_sample(0, -32768, 0);
      send_sample(0, 0, 32767);
      send_sample(0, 0, -32768);
      send_sample(-32768, -32768, -32768);
      send_sample(32767, 32767, 32767);
      send_sample(1, 0, 0);
      send_sample(0, 0, 1);
      send_sample(-1, -1, -1);
      send_sample(32767, -32768, 1);
      send_sample(12288, 0, 0);
      send_sample(12287, 0, 0);
      send_sample(0, 20480, 0);
      send_sample(0, 20481, 0);
      send_sample(0, 0, -16384);
      send_sample(0, -12288, 0);
      send_sample(0, 0, 20480);
      send_sample(11585, 0, 11585);
      drain_results();
   endtask

   task automatic test_near_one_g();
      send_random_run(300);
      drain_results();
   endtask

   // zero scale forces the norm flag low
   task automatic test_zero_counts_per_g();
      write_counts_per_g(cpg_type'(0));
      send_sample(0, 0, 16384);
      send_sample(0, 0, 0);
      send_random_run(150);
      drain_results();
   endtask

   task automatic test_full_scale_counts_per_g();
      write_counts_per_g(cpg_type'(32767));
      send_sample(0, 0, 32767);
      send_sample(-24576, 0, 0);
      send_sample(-32768, -32768, -32768);
      send_random_run(250);
      drain_results();
   endtask

   task automatic test_unit_counts_per_g();
      write_counts_per_g(cpg_type'(1));
      send_sample(1, 0, 0);
      send_sample(0, -1, 0);
      send_sample(1, 1, 0);
      send_random_run(100);
      drain_results();
   endtask

   task automatic test_random_counts_per_g();
      for (int p = 0; p < 4; p++) begin
         write_counts_per_g(cpg_type'($urandom_range(1, 32766)));
         send_random_run(150);
         drain_results();
      end
      write_counts_per_g(cpg_type'(CPG_RESET));
      send_random_run(30);
      drain_results();
   endtask

   // result check against the oldest pending expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: tilt_angle %0d, norm_ok %0d",
                   rsp_tilt_angle, rsp_norm_ok);
            fail_count++;
         end else begin
            head = awaited_results.pop_front();
            if (rsp_tilt_angle !== head.tilt_angle) begin
               $error("tilt_angle mismatch: expected %0d, actual %0d",
                      head.tilt_angle, rsp_tilt_angle);
               fail_count++;
            end
            if (rsp_norm_ok !== head.norm_ok) begin
               $error("norm_ok mismatch: expected %0d, actual %0d",
                      head.norm_ok, rsp_norm_ok);
               fail_count++;
            end
         end
      end
   end

   // receiver stall pattern: free flow, light, heavy or square-wave backpressure
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= stall_left[3];
         end
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL accel_tilt_and_norm_check");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_near_one_g();
      test_zero_counts_per_g();
      test_full_scale_counts_per_g();
      test_unit_counts_per_g();
      test_random_counts_per_g();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS accel_tilt_and_norm_check");
      end else begin
         $display("FAIL accel_tilt_and_norm_check");
      end
      $finish;
   end

endmodule
